// ===== rtl/sgi_rle_line_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Run-length line decoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef SGI_RLE_LINE_DECODER_MACROS_SVH
`define SGI_RLE_LINE_DECODER_MACROS_SVH

// checked only out of reset
`define SRLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define SRLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/srld_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package srld_pkg;

  localparam int unsigned PixelWidth = 16;
  localparam int unsigned RunWidth   = 7;
  localparam int unsigned SpaceWidth = 15;

  localparam logic [SpaceWidth-1:0] MaxLineWidth = 15'd4096;
  localparam logic [SpaceWidth-1:0] LineWidthRst = MaxLineWidth;

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_LIT   = 2'd1,
    PH_REP   = 2'd2,
    PH_DRAIN = 2'd3
  } phase_e;

  typedef enum logic {
    SQ_ACCEPT = 1'b0,
    SQ_REPEAT = 1'b1
  } seq_state_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_LIT_SHORT = 3'd2,
    ST_REP_SHORT = 3'd3,
    ST_NO_TERM   = 3'd4
  } status_e;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel_first;
    logic [PixelWidth-1:0] pixel_second;
    logic [1:0]            pixel_count;
    logic                  last_of_burst;
    logic                  line_end;
    status_e               status;
  } result_t;

endpackage

// ===== rtl/srld_obuf.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module srld_obuf
  import srld_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = res_valid_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/srld_seq.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder sequencer
// Decode state, line width register and the shared subtractor that checks
// space, counts down literal runs and steps replicate runs two pixels a cycle while the output register is free.
// ----------------------------------------------------------------------------
`include "sgi_rle_line_decoder_macros.svh"

module srld_seq
  import srld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [SpaceWidth-1:0] line_width_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PixelWidth-1:0] element_value_i,
  input  logic                  last_element_i,
  input  logic                  obuf_free_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  seq_state_e            state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [RunWidth-1:0]   run_left_q, run_left_d;
  logic [SpaceWidth-1:0] space_left_q, space_left_d;
  logic [SpaceWidth-1:0] line_width_q;
  logic [PixelWidth-1:0] rep_value_q, rep_value_d;
  logic                  rep_last_q, rep_last_d;

  logic [SpaceWidth-1:0] width_use;
  logic [SpaceWidth-1:0] sub_a, sub_b, sub_diff;
  logic                  sub_borrow;
  logic                  in_fire;
  logic [RunWidth-1:0]   ctrl_count;
  logic                  pair;

  assign cfg_ready_o = 1'b1;
  assign width_use   = (line_width_q > MaxLineWidth) ? MaxLineWidth : line_width_q;
  assign in_stall_o  = (state_q == SQ_REPEAT) || !obuf_free_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign ctrl_count  = element_value_i[RunWidth-1:0];
  assign pair        = (run_left_q[RunWidth-1:1] != '0);

  // shared subtractor
  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    run_left_d   = run_left_q;
    space_left_d = space_left_q;
    rep_value_d  = rep_value_q;
    rep_last_d   = rep_last_q;
    res_valid_o  = 1'b0;
    res_o        = '{pixel_first: '0, pixel_second: '0, pixel_count: 2'd0,
                     last_of_burst: 1'b1, line_end: 1'b0, status: ST_OK};
    sub_a        = space_left_q;
    sub_b        = {{(SpaceWidth-RunWidth){1'b0}}, ctrl_count};

    unique case (state_q)
      SQ_ACCEPT: begin
        unique case (phase_q)
          PH_CTRL: begin
            sub_a = space_left_q;
            sub_b = {{(SpaceWidth-RunWidth){1'b0}}, ctrl_count};
          end
          PH_LIT: begin
            sub_a = {{(SpaceWidth-RunWidth){1'b0}}, run_left_q};
            sub_b = {{(SpaceWidth-1){1'b0}}, 1'b1};
          end
          default: begin
            sub_a = space_left_q;
            sub_b = {{(SpaceWidth-RunWidth){1'b0}}, ctrl_count};
          end
        endcase
        if (in_fire) begin
          unique case (phase_q)
            PH_DRAIN: begin
              if (last_element_i) begin
                phase_d      = PH_CTRL;
                space_left_d = width_use;
              end
            end
            PH_CTRL: begin
              if ((ctrl_count == '0) || sub_borrow || last_element_i) begin
                res_valid_o      = 1'b1;
                res_o.line_end   = 1'b1;
                run_left_d       = '0;
                if (ctrl_count == '0) begin
                  res_o.status = ST_OK;
                end else if (sub_borrow) begin
                  res_o.status = ST_OVERFLOW;
                end else begin
                  res_o.status = element_value_i[7] ? ST_LIT_SHORT : ST_REP_SHORT;
                end
                if (last_element_i) begin
                  phase_d      = PH_CTRL;
                  space_left_d = width_use;
                end else begin
                  phase_d = PH_DRAIN;
                end
              end else begin
                space_left_d = sub_diff;
                run_left_d   = ctrl_count;
                phase_d      = element_value_i[7] ? PH_LIT : PH_REP;
              end
            end
            PH_LIT: begin
              res_valid_o       = 1'b1;
              res_o.pixel_first = element_value_i;
              res_o.pixel_count = 2'd1;
              res_o.line_end    = last_element_i;
              if (last_element_i) begin
                res_o.status = (sub_diff[RunWidth-1:0] == '0) ? ST_NO_TERM : ST_LIT_SHORT;
                run_left_d   = '0;
                phase_d      = PH_CTRL;
                space_left_d = width_use;
              end else begin
                run_left_d = sub_diff[RunWidth-1:0];
                if (sub_diff[RunWidth-1:0] == '0) begin
                  phase_d = PH_CTRL;
                end
              end
            end
            PH_REP: begin
              rep_value_d = element_value_i;
              rep_last_d  = last_element_i;
              state_d     = SQ_REPEAT;
            end
            default: begin
            end
          endcase
        end
      end
      SQ_REPEAT: begin
        sub_a = {{(SpaceWidth-RunWidth){1'b0}}, run_left_q};
        sub_b = pair ? SpaceWidth'(2) : SpaceWidth'(1);
        if (obuf_free_i) begin
          res_valid_o = 1'b1;
          if ((run_left_q == '0) || (sub_diff[RunWidth-1:0] == '0)) begin
            if (run_left_q != '0) begin
              res_o.pixel_first  = rep_value_q;
              res_o.pixel_second = pair ? rep_value_q : '0;
              res_o.pixel_count  = pair ? 2'd2 : 2'd1;
            end
            res_o.line_end = rep_last_q;
            res_o.status   = rep_last_q ? ST_NO_TERM : ST_OK;
            run_left_d     = '0;
            phase_d        = PH_CTRL;
            state_d        = SQ_ACCEPT;
            if (rep_last_q) begin
              space_left_d = width_use;
            end
          end else begin
            res_o.pixel_first   = rep_value_q;
            res_o.pixel_second  = pair ? rep_value_q : '0;
            res_o.pixel_count   = pair ? 2'd2 : 2'd1;
            res_o.last_of_burst = 1'b0;
            run_left_d          = sub_diff[RunWidth-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SQ_ACCEPT;
      phase_q      <= PH_CTRL;
      run_left_q   <= '0;
      space_left_q <= MaxLineWidth;
      line_width_q <= LineWidthRst;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      run_left_q   <= run_left_d;
      space_left_q <= space_left_d;
      if (cfg_valid_i && cfg_ready_o) begin
        line_width_q <= line_width_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rep_value_q <= rep_value_d;
    rep_last_q  <= rep_last_d;
  end

  `SRLD_ASSERT(a_push_into_free, res_valid_o |-> obuf_free_i, "result pushed into full output register")
  `SRLD_ASSERT(a_space_bound, space_left_q <= MaxLineWidth, "space left beyond line width")
  `SRLD_ASSERT(a_run_nonzero, ((phase_q == PH_LIT) || (phase_q == PH_REP)) |-> (run_left_q != '0), "open run with zero length")
  `SRLD_ASSERT(a_status_with_end, (res_valid_o && !res_o.line_end) |-> (res_o.status == ST_OK), "error status without line end")
  `SRLD_ASSERT(a_repeat_progress, ((state_q == SQ_REPEAT) && obuf_free_i && (run_left_q > 7'd2)) |=> ((state_q == SQ_REPEAT) && (run_left_q == $past(run_left_q) - 7'd2)), "replicate run not stepping by two")

endmodule

// ===== rtl/sgi_rle_line_decoder.sv =====
// ----------------------------------------------------------------------------
// Run-length scanline decoder
// Top level: sequencer with shared subtractor, and output register.
// ----------------------------------------------------------------------------
// Control, literal and drained elements are taken whenever the input is not
// stalled. A replicate value element is accepted into the repeat state, which
// then issues the run's results, since the output register carries two pixels
// and the shared subtractor steps the run counter down by up to two per result;
// input stall stays high meanwhile. Any cycle the output is stalled with a
// result waiting also stalls the input. line_width is written on its own
// channel, always ready, and takes effect at the next line start.

module sgi_rle_line_decoder
  import srld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [SpaceWidth-1:0] line_width_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PixelWidth-1:0] element_value_i,
  input  logic                  last_element_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PixelWidth-1:0] pixel_first_o,
  output logic [PixelWidth-1:0] pixel_second_o,
  output logic [1:0]            pixel_count_o,
  output logic                  last_of_burst_o,
  output logic                  line_end_o,
  output logic [2:0]            status_o
);

  logic    obuf_free;
  logic    res_valid;
  result_t res, res_out;

  srld_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .line_width_i    (line_width_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .last_element_i  (last_element_i),
    .obuf_free_i     (obuf_free),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  srld_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (obuf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign pixel_first_o   = res_out.pixel_first;
  assign pixel_second_o  = res_out.pixel_second;
  assign pixel_count_o   = res_out.pixel_count;
  assign last_of_burst_o = res_out.last_of_burst;
  assign line_end_o      = res_out.line_end;
  assign status_o        = res_out.status;

endmodule
